// ----- sv/ppu_pkg.sv -----
// shared types, constants and functions of the particle pool update block
package ppu_pkg;

    localparam int POOL_SLOTS_DEF   = 64;
    localparam int FADE_ENTRIES_DEF = 256;
    localparam int AXIS_W           = 20;
    localparam int VEC_W            = 3 * AXIS_W;
    localparam int DIV_STEPS        = 17;

    localparam logic signed [47:0] AXIS_HI = (48'sd1 <<< (AXIS_W - 1)) - 48'sd1;
    localparam logic signed [47:0] AXIS_LO = -(48'sd1 <<< (AXIS_W - 1));

    typedef enum logic [1:0] {
        OP_SPAWN   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef logic [2:0][AXIS_W-1:0] t_axes;

    typedef struct packed {
        t_axes              pos;
        t_axes              vel;
        logic [15:0]        age;
        logic [23:0]        colour;
        logic [15:0]        life;
        logic [11:0]        size;
        logic [9:0]         growth;
        logic signed [11:0] gravity;
        logic [11:0]        drag;
        logic [7:0]         peak;
    } t_slot;

    function automatic logic [AXIS_W-1:0] sat_axis(input logic signed [47:0] v);
        logic signed [47:0] c;
        c = v;
        if (v > AXIS_HI) c = AXIS_HI;
        if (v < AXIS_LO) c = AXIS_LO;
        return c[AXIS_W-1:0];
    endfunction

    // x^1.4 in q16 for x in q16, x^0.4 found by a binary search on y^5
    function automatic logic [16:0] fade_pow(input longint unsigned x);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        longint unsigned e;
        target = (x * x) << 28;
        lo = 0;
        hi = 4096;
        for (int it = 0; it < 14; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                p = mid * mid * mid * mid * mid;
                if (p <= target) lo = mid;
                else hi = mid - 1;
            end
        end
        e = (x * lo + 2048) >> 12;
        if (e > 65536) e = 65536;
        return e[16:0];
    endfunction

endpackage

// ----- sv/ppu_if.sv -----
// input and result channel interfaces of the particle pool update block
interface ppu_in_if import ppu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [VEC_W-1:0]   position_packed;
    logic [VEC_W-1:0]   velocity_packed;
    logic [23:0]        colour_rgb;
    logic [15:0]        life_span;
    logic [11:0]        start_size;
    logic [9:0]         growth_rate;
    logic signed [11:0] gravity_accel;
    logic [11:0]        drag_rate;
    logic [7:0]         peak_alpha;
    logic [11:0]        tick_dt;

    modport source (
        output valid, operation, position_packed, velocity_packed, colour_rgb,
               life_span, start_size, growth_rate, gravity_accel, drag_rate,
               peak_alpha, tick_dt,
        input  ready
    );
    modport sink (
        input  valid, operation, position_packed, velocity_packed, colour_rgb,
               life_span, start_size, growth_rate, gravity_accel, drag_rate,
               peak_alpha, tick_dt,
        output ready
    );
endinterface

interface ppu_out_if import ppu_pkg::*; #(
    parameter int IDX_W = $clog2(POOL_SLOTS_DEF)
) ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] slot_index;
    logic             slot_valid;
    logic [VEC_W-1:0] centre_packed;
    logic [15:0]      radius_now;
    logic [7:0]       alpha_now;
    logic [23:0]      colour_out;
    logic             last_slot;

    modport source (
        output valid, slot_index, slot_valid, centre_packed, radius_now, alpha_now,
               colour_out, last_slot,
        input  ready
    );
    modport sink (
        input  valid, slot_index, slot_valid, centre_packed, radius_now, alpha_now,
               colour_out, last_slot,
        output ready
    );
endinterface

// ----- sv/particle_pool_update.sv -----
// particle pool update: slot memory, advance sequencer and per-slot result path
//
//  channel  dir  word                                   accepted when
//  i_in     in   operation, spawn fields, tick_dt       valid && ready
//  o_res    out  slot_index, slot_valid, centre, ...    valid && ready
//
// spawn and clear are done from idle; an advance walks live slots top down, survivors
// and removed particles alike, all through the one slot memory
// the result pass then runs each live slot through the serial fade divider and gives
// POOL_SLOTS results in all, one per slot, empty slots included
// reset clears the state, the live count and the result valid flag; slot memory is not cleared
// a stalled result holds the pass at that slot; a new word is taken only when idle
module particle_pool_update import ppu_pkg::*; #(
    parameter int POOL_SLOTS         = POOL_SLOTS_DEF,
    parameter int FADE_TABLE_ENTRIES = FADE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppu_in_if.sink     i_in,
    ppu_out_if.source  o_res
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int FI_W  = $clog2(FADE_TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(POOL_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(POOL_SLOTS);
    localparam logic [FI_W-1:0]  FADE_MAXI  = FI_W'(FADE_TABLE_ENTRIES - 1);
    localparam logic [11:0]      FADE_MAX12 = 12'(FADE_TABLE_ENTRIES - 1);
    localparam logic [10:0]      FADE_SCALE = 11'(FADE_TABLE_ENTRIES - 1);

    typedef enum logic [16:0] {
        S_IDLE  = 17'd1 << 0,
        S_ARD   = 17'd1 << 1,
        S_AEVAL = 17'd1 << 2,
        S_AMOV  = 17'd1 << 3,
        S_AKK   = 17'd1 << 4,
        S_AF    = 17'd1 << 5,
        S_AVM   = 17'd1 << 6,
        S_AVD   = 17'd1 << 7,
        S_APA   = 17'd1 << 8,
        S_AWR   = 17'd1 << 9,
        S_ORD   = 17'd1 << 10,
        S_OPRE  = 17'd1 << 11,
        S_ODIV  = 17'd1 << 12,
        S_OIDX  = 17'd1 << 13,
        S_OLUT  = 17'd1 << 14,
        S_OEMIT = 17'd1 << 15,
        S_SPARE = 17'd1 << 16
    } t_state;

    // fade curve table, built at elaboration
    logic [16:0] fade_tab [FADE_TABLE_ENTRIES];
    for (genvar gi = 0; gi < FADE_TABLE_ENTRIES; gi++) begin : g_fade
        localparam longint unsigned X = (longint'(gi) * 65536) / (FADE_TABLE_ENTRIES - 1);
        localparam logic [16:0] E = fade_pow(X);
        assign fade_tab[gi] = E;
    end

    t_slot r_mem [POOL_SLOTS];
    t_slot r_rd;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_slot            mem_wdata;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic [11:0]        r_dt, n_dt;
    t_slot              r_w, n_w;
    logic signed [24:0] r_gk, n_gk;
    logic [23:0]        r_k, n_k;
    logic [47:0]        r_kk, n_kk;
    logic [20:0]        r_f, n_f;
    logic [1:0]         r_ax, n_ax;
    logic signed [41:0] r_prod, n_prod;
    logic signed [32:0] r_pd, n_pd;
    logic               r_live, n_live;
    logic [15:0]        r_rad, n_rad;
    logic               r_case1, n_case1;
    logic [22:0]        r_dden, n_dden;
    logic [22:0]        r_drem, n_drem;
    logic [16:0]        r_dnum, n_dnum;
    logic [4:0]         r_dstep, n_dstep;
    logic [FI_W-1:0]    r_idx, n_idx;
    logic [16:0]        r_fade, n_fade;
    logic               r_ov, n_ov;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic               r_o_live, n_o_live;
    logic [VEC_W-1:0]   r_o_centre, n_o_centre;
    logic [15:0]        r_o_rad, n_o_rad;
    logic [7:0]         r_o_alpha, n_o_alpha;
    logic [23:0]        r_o_colour, n_o_colour;
    logic               r_o_last, n_o_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd <= r_mem[mem_raddr];
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_ov;
    assign o_res.slot_index    = r_o_idx;
    assign o_res.slot_valid    = r_o_live;
    assign o_res.centre_packed = r_o_centre;
    assign o_res.radius_now    = r_o_rad;
    assign o_res.alpha_now     = r_o_alpha;
    assign o_res.colour_out    = r_o_colour;
    assign o_res.last_slot     = r_o_last;

    always_comb begin
        logic [CNT_W-1:0]   cnt_m1;
        logic [IDX_W-1:0]   down_slot;
        t_state             down_state;
        logic [16:0]        age_sum;
        logic signed [47:0] gadd;
        logic signed [47:0] vz_sum;
        logic [28:0]        f_raw;
        logic signed [47:0] vround;
        logic [AXIS_W-1:0]  v_new;
        logic signed [47:0] pd_round;
        logic signed [47:0] p_sum;
        logic [15:0]        life_nz;
        logic [15:0]        g_min;
        logic [22:0]        g100;
        logic [22:0]        lg100;
        logic [22:0]        l12;
        logic [22:0]        l88;
        logic               case1;
        logic [38:0]        num;
        logic [25:0]        gr_prod;
        logic [16:0]        rad_sum;
        logic [23:0]        div_t;
        logic               div_ge;
        logic [16:0]        u_cl;
        logic [27:0]        idx_prod;
        logic [11:0]        idx_raw;
        logic [24:0]        al_prod;
        logic [8:0]         al_raw;

        n_state = r_state;  n_cnt = r_cnt;    n_slot = r_slot;  n_dt = r_dt;
        n_w = r_w;          n_gk = r_gk;      n_k = r_k;        n_kk = r_kk;
        n_f = r_f;          n_ax = r_ax;      n_prod = r_prod;  n_pd = r_pd;
        n_live = r_live;    n_rad = r_rad;    n_case1 = r_case1;
        n_dden = r_dden;    n_drem = r_drem;  n_dnum = r_dnum;  n_dstep = r_dstep;
        n_idx = r_idx;      n_fade = r_fade;
        n_ov = r_ov;        n_o_idx = r_o_idx;        n_o_live = r_o_live;
        n_o_centre = r_o_centre;  n_o_rad = r_o_rad;  n_o_alpha = r_o_alpha;
        n_o_colour = r_o_colour;  n_o_last = r_o_last;

        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_raddr = r_slot;
        mem_wdata = r_w;

        cnt_m1 = r_cnt - 1'b1;
        if (r_slot == '0) begin
            down_slot  = '0;
            down_state = S_ORD;
        end else begin
            down_slot  = r_slot - 1'b1;
            down_state = S_ARD;
        end

        age_sum  = 17'(r_rd.age) + 17'(r_dt);
        gadd     = (48'(r_gk) + 48'sd128) >>> 8;
        vz_sum   = 48'($signed(r_w.vel[2])) + gadd;
        f_raw    = (29'd1 << 20) + 29'((r_kk + 48'd1048576) >> 21) - 29'(r_k);
        vround   = (48'(r_prod) + 48'sd524288) >>> 20;
        v_new    = sat_axis(vround);
        pd_round = (48'(r_pd) + 48'sd2048) >>> 12;
        p_sum    = 48'($signed(r_w.pos[r_ax])) + pd_round;

        life_nz = (r_rd.life == 16'd0) ? 16'd1 : r_rd.life;
        g_min   = (r_rd.age < life_nz) ? r_rd.age : life_nz;
        g100    = 23'(g_min) * 23'd100;
        lg100   = 23'(life_nz - g_min) * 23'd100;
        l12     = 23'(life_nz) * 23'd12;
        l88     = 23'(life_nz) * 23'd88;
        case1   = (g100 < l12);
        num     = {(case1 ? g100 : lg100), 16'd0};
        gr_prod = 26'(r_rd.growth) * 26'(r_rd.age);
        rad_sum = 17'(r_rd.size) + 17'((gr_prod + 26'd2048) >> 12);

        div_t  = {r_drem, r_dnum[16]};
        div_ge = (div_t >= {1'b0, r_dden});

        u_cl     = (r_dnum > 17'd65536) ? 17'd65536 : r_dnum;
        idx_prod = 28'(u_cl) * 28'(FADE_SCALE) + 28'd32768;
        idx_raw  = idx_prod[27:16];

        al_prod = 25'(r_fade) * 25'(r_w.peak) + 25'd32768;
        al_raw  = al_prod[24:16];

        if (o_res.ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.operation)
                        OP_SPAWN: begin
                            if (r_cnt < FULL_CNT) begin
                                mem_we            = 1'b1;
                                mem_waddr         = r_cnt[IDX_W-1:0];
                                mem_wdata.pos     = i_in.position_packed;
                                mem_wdata.vel     = i_in.velocity_packed;
                                mem_wdata.age     = 16'd0;
                                mem_wdata.colour  = i_in.colour_rgb;
                                mem_wdata.life    = i_in.life_span;
                                mem_wdata.size    = i_in.start_size;
                                mem_wdata.growth  = i_in.growth_rate;
                                mem_wdata.gravity = i_in.gravity_accel;
                                mem_wdata.drag    = i_in.drag_rate;
                                mem_wdata.peak    = i_in.peak_alpha;
                                n_cnt             = r_cnt + 1'b1;
                            end
                        end
                        OP_ADVANCE: begin
                            n_dt = i_in.tick_dt;
                            if (r_cnt == '0) begin
                                n_slot  = '0;
                                n_state = S_ORD;
                            end else begin
                                n_slot  = cnt_m1[IDX_W-1:0];
                                n_state = S_ARD;
                            end
                        end
                        OP_CLEAR: n_cnt = '0;
                        default: ;
                    endcase
                end
            end
            S_ARD: n_state = S_AEVAL;
            S_AEVAL: begin
                n_w     = r_rd;
                n_w.age = age_sum[15:0];
                n_gk    = 25'($signed(r_rd.gravity)) * 25'($signed({1'b0, r_dt}));
                n_k     = 24'(r_rd.drag) * 24'(r_dt);
                if (age_sum >= 17'(r_rd.life)) begin
                    n_cnt = cnt_m1;
                    if (r_slot != cnt_m1[IDX_W-1:0]) begin
                        mem_raddr = cnt_m1[IDX_W-1:0];
                        n_state   = S_AMOV;
                    end else begin
                        n_slot  = down_slot;
                        n_state = down_state;
                    end
                end else begin
                    n_state = S_AKK;
                end
            end
            S_AMOV: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd;
                n_slot    = down_slot;
                n_state   = down_state;
            end
            S_AKK: begin
                n_kk       = 48'(r_k) * 48'(r_k);
                n_w.vel[2] = sat_axis(vz_sum);
                n_state    = S_AF;
            end
            S_AF: begin
                n_f     = (f_raw > (29'd1 << 20)) ? (21'd1 << 20) : f_raw[20:0];
                n_ax    = 2'd0;
                n_state = S_AVM;
            end
            S_AVM: begin
                n_prod  = 42'($signed(r_w.vel[r_ax])) * 42'($signed({1'b0, r_f}));
                n_state = S_AVD;
            end
            S_AVD: begin
                n_w.vel[r_ax] = v_new;
                n_pd          = 33'($signed(v_new)) * 33'($signed({1'b0, r_dt}));
                n_state       = S_APA;
            end
            S_APA: begin
                n_w.pos[r_ax] = sat_axis(p_sum);
                if (r_ax == 2'd2) begin
                    n_state = S_AWR;
                end else begin
                    n_ax    = r_ax + 1'b1;
                    n_state = S_AVM;
                end
            end
            S_AWR: begin
                mem_we  = 1'b1;
                n_slot  = down_slot;
                n_state = down_state;
            end
            S_ORD: begin
                if (CNT_W'(r_slot) < r_cnt) begin
                    n_state = S_OPRE;
                end else begin
                    n_live  = 1'b0;
                    n_state = S_OEMIT;
                end
            end
            S_OPRE: begin
                n_w     = r_rd;
                n_live  = 1'b1;
                n_case1 = case1;
                n_drem  = {1'b0, num[38:17]};
                n_dnum  = num[16:0];
                n_dden  = case1 ? l12 : l88;
                n_dstep = '0;
                n_rad   = (rad_sum > 17'd65535) ? 16'hFFFF : rad_sum[15:0];
                n_state = S_ODIV;
            end
            S_ODIV: begin
                n_drem  = div_ge ? 23'(div_t - {1'b0, r_dden}) : div_t[22:0];
                n_dnum  = {r_dnum[15:0], div_ge};
                n_dstep = r_dstep + 1'b1;
                if (r_dstep == 5'(DIV_STEPS - 1)) n_state = S_OIDX;
            end
            S_OIDX: begin
                n_idx   = (idx_raw > FADE_MAX12) ? FADE_MAXI : idx_raw[FI_W-1:0];
                n_state = S_OLUT;
            end
            S_OLUT: begin
                n_fade  = r_case1 ? r_dnum : fade_tab[r_idx];
                n_state = S_OEMIT;
            end
            S_OEMIT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov       = 1'b1;
                    n_o_idx    = r_slot;
                    n_o_live   = r_live;
                    n_o_last   = (r_slot == LAST_IDX);
                    n_o_centre = r_live ? r_w.pos : '0;
                    n_o_rad    = r_live ? r_rad : 16'd0;
                    n_o_colour = r_live ? r_w.colour : 24'd0;
                    n_o_alpha  = !r_live ? 8'd0 :
                                 (al_raw > 9'd255) ? 8'd255 : al_raw[7:0];
                    if (r_slot == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;    r_dt <= n_dt;      r_w <= n_w;
        r_gk <= n_gk;        r_k <= n_k;        r_kk <= n_kk;
        r_f <= n_f;          r_ax <= n_ax;      r_prod <= n_prod;
        r_pd <= n_pd;        r_live <= n_live;  r_rad <= n_rad;
        r_case1 <= n_case1;  r_dden <= n_dden;  r_drem <= n_drem;
        r_dnum <= n_dnum;    r_dstep <= n_dstep;
        r_idx <= n_idx;      r_fade <= n_fade;
        r_o_idx <= n_o_idx;  r_o_live <= n_o_live;  r_o_centre <= n_o_centre;
        r_o_rad <= n_o_rad;  r_o_alpha <= n_o_alpha;
        r_o_colour <= n_o_colour;  r_o_last <= n_o_last;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("live count beyond pool size");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ODIV |-> r_drem < r_dden)
        else $error("divider remainder not below divisor");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last_slot |-> o_res.slot_index == LAST_IDX)
        else $error("last flag on wrong slot");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.slot_valid |->
            o_res.alpha_now == 8'd0 && o_res.radius_now == 16'd0 &&
            o_res.centre_packed == '0 && o_res.colour_out == 24'd0)
        else $error("empty slot word carries data");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !o_res.last_slot |=>
            !o_res.valid || o_res.slot_index == IDX_W'($past(o_res.slot_index) + 1'b1))
        else $error("result slots out of order");

endmodule
